[rtl/core/point_cloud_to_range_scan_macros.svh]
// Assertion macros used by the checker file.
`ifndef POINT_CLOUD_TO_RANGE_SCAN_MACROS_SVH
`define POINT_CLOUD_TO_RANGE_SCAN_MACROS_SVH

// Same-cycle implication, sampled on clk, idle during reset.
`define PC2RS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pc2rs check failed");

// Next-cycle implication, sampled on clk, idle during reset.
`define PC2RS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pc2rs check failed");

`endif

[rtl/core/pc2rs_pkg.sv]
package pc2rs_pkg;

	localparam int NUM_BINS_DEF = 523;
	localparam logic [12:0] EMPTY_RANGE = 13'd6600;
	localparam logic signed [21:0] WIN_LO_FX = -22'sd1647100;
	localparam logic signed [21:0] WIN_HI_FX = 22'sd1640665;
	localparam logic signed [21:0] NEG_QUARTER = -22'sd1647099;
	localparam logic [6:0] BIN_NUM = 7'd125;
	// Reciprocal of three in 2^-17 units, used after the shift by 2^18.
	localparam logic [15:0] RECIP3 = 16'd43691;
	localparam int CORDIC_STEPS = 20;
	localparam int SQRT_STEPS = 16;

	localparam logic [1:0] CFG_MIN_HEIGHT = 2'd0;
	localparam logic [1:0] CFG_MAX_HEIGHT = 2'd1;

	// Codes on the operation field of a request.
	localparam logic OP_ACCUM = 1'b0;
	localparam logic OP_READ  = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic       load;
		logic       cordic_step;
		logic [4:0] iter;
		logic       scale;
		logic       divide;
		logic       lookup;
		logic       update;
		logic       rd_read;
		logic       reply;
		logic       clear_wr;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic drop;
		logic out_busy;
	} status_t;

	function automatic logic signed [21:0] atan_entry(input logic [4:0] i);
		logic signed [21:0] r;
		case (i)
			5'd0: r = 22'sd823550;
			5'd1: r = 22'sd486170;
			5'd2: r = 22'sd256879;
			5'd3: r = 22'sd130396;
			5'd4: r = 22'sd65451;
			5'd5: r = 22'sd32757;
			5'd6: r = 22'sd16383;
			5'd7: r = 22'sd8192;
			5'd8: r = 22'sd4096;
			5'd9: r = 22'sd2048;
			5'd10: r = 22'sd1024;
			5'd11: r = 22'sd512;
			5'd12: r = 22'sd256;
			5'd13: r = 22'sd128;
			5'd14: r = 22'sd64;
			5'd15: r = 22'sd32;
			5'd16: r = 22'sd16;
			5'd17: r = 22'sd8;
			5'd18: r = 22'sd4;
			5'd19: r = 22'sd2;
			default: r = 22'sd0;
		endcase
		return r;
	endfunction

endpackage

[rtl/core/pc2rs_ctrl.sv]
module pc2rs_ctrl #(
	parameter int NUM_BINS = pc2rs_pkg::NUM_BINS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        operation,
	input  pc2rs_pkg::status_t          status,
	output logic                        in_stall,
	output pc2rs_pkg::cmd_t             cmd,
	output logic [$clog2(NUM_BINS)-1:0] clr_addr
);

	localparam int AW = $clog2(NUM_BINS);

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_CORDIC, ST_SCALE, ST_DIVIDE, ST_LOOKUP, ST_UPDATE,
		ST_READ, ST_REPLY
	} state_t;

	state_t     state_q;
	logic [4:0] iter_q;
	logic [AW-1:0] clr_q;
	logic       accept;

	assign in_stall = (state_q != ST_IDLE);
	assign accept = in_valid && (state_q == ST_IDLE);
	assign clr_addr = clr_q;

	always_comb begin
		cmd = '0;
		cmd.load = accept;
		cmd.iter = iter_q;
		cmd.cordic_step = (state_q == ST_CORDIC);
		cmd.scale = (state_q == ST_SCALE);
		cmd.divide = (state_q == ST_DIVIDE);
		cmd.lookup = (state_q == ST_LOOKUP);
		cmd.update = (state_q == ST_UPDATE);
		cmd.rd_read = (state_q == ST_READ);
		cmd.reply = (state_q == ST_REPLY) && !status.out_busy;
		cmd.clear_wr = (state_q == ST_CLEAR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			iter_q <= '0;
			clr_q <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(NUM_BINS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					iter_q <= '0;
					if (accept) begin
						if (operation == pc2rs_pkg::OP_READ) begin
							state_q <= ST_READ;
						end else if (!status.drop) begin
							state_q <= ST_CORDIC;
						end
					end
				end
				ST_CORDIC: begin
					iter_q <= iter_q + 5'd1;
					if (iter_q == 5'(pc2rs_pkg::CORDIC_STEPS - 1)) begin
						state_q <= ST_SCALE;
					end
				end
				ST_SCALE: state_q <= ST_DIVIDE;
				ST_DIVIDE: state_q <= ST_LOOKUP;
				ST_LOOKUP: state_q <= ST_UPDATE;
				ST_UPDATE: state_q <= ST_IDLE;
				ST_READ: state_q <= ST_REPLY;
				ST_REPLY: begin
					if (!status.out_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[rtl/core/pc2rs_dp.sv]
module pc2rs_dp #(
	parameter int NUM_BINS = pc2rs_pkg::NUM_BINS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  pc2rs_pkg::cmd_t             cmd,
	input  logic [$clog2(NUM_BINS)-1:0] clr_addr,
	output pc2rs_pkg::status_t          status,
	input  logic signed [15:0]          fwd_mm,
	input  logic signed [15:0]          side_mm,
	input  logic signed [15:0]          vert_mm,
	input  logic                        point_invalid,
	input  logic [9:0]                  bin_select,
	input  logic                        cfg_valid,
	input  logic [1:0]                  cfg_index,
	input  logic signed [15:0]          cfg_data,
	input  logic                        out_stall,
	output logic                        out_valid,
	output logic [12:0]                 range_mm,
	output logic [9:0]                  bin_echo
);

	localparam int AW = $clog2(NUM_BINS);

	logic signed [15:0] min_h_q, max_h_q;
	logic signed [18:0] x_q, y_q, xs, ys;
	logic signed [21:0] z_q, tab, angle;
	logic               axis_q;
	logic signed [15:0] side_q;
	logic [31:0]        n_q, root_q, bit_w, trial;
	logic [9:0]         sel_q;
	logic               sel_ok;
	logic signed [22:0] diff;
	logic [28:0]        prod_s1;
	logic               win_s1;
	logic [26:0]        prod2;
	logic [9:0]         bin_s2;
	logic               ok_s2, ok_s3;
	logic [12:0]        rdata_q;
	logic [12:0]        bin_mem_q [NUM_BINS];
	logic               we, re;
	logic [AW-1:0]      wa, ra;
	logic [12:0]        wd;
	logic               out_valid_q;
	logic [12:0]        range_q;
	logic [9:0]         echo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_h_q <= 16'sd100;
			max_h_q <= 16'sd150;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				pc2rs_pkg::CFG_MIN_HEIGHT: min_h_q <= cfg_data;
				pc2rs_pkg::CFG_MAX_HEIGHT: max_h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign status.drop = point_invalid || (vert_mm > max_h_q) || (vert_mm < min_h_q) ||
		(fwd_mm < 16'sd0) || ((fwd_mm == 16'sd0) && (side_mm > 16'sd0));
	assign status.out_busy = out_valid_q && out_stall;

	assign xs = x_q >>> cmd.iter;
	assign ys = y_q >>> cmd.iter;
	assign tab = pc2rs_pkg::atan_entry(cmd.iter);
	assign bit_w = 32'd1 << (6'd30 - {cmd.iter, 1'b0});
	assign trial = root_q + bit_w;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= 19'(fwd_mm);
			y_q <= 19'(side_mm);
			z_q <= '0;
			axis_q <= (fwd_mm == 16'sd0);
			side_q <= side_mm;
			n_q <= 32'(fwd_mm) * 32'(fwd_mm) + 32'(side_mm) * 32'(side_mm);
			root_q <= '0;
			sel_q <= bin_select;
		end else if (cmd.cordic_step) begin
			if (y_q >= 19'sd0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + tab;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - tab;
			end
			// The root needs fewer steps and runs alongside the bearing.
			if (cmd.iter < 5'(pc2rs_pkg::SQRT_STEPS)) begin
				if (n_q >= trial) begin
					n_q <= n_q - trial;
					root_q <= (root_q >> 1) + bit_w;
				end else begin
					root_q <= root_q >> 1;
				end
			end
		end
	end

	assign angle = axis_q ? ((side_q < 16'sd0) ? pc2rs_pkg::NEG_QUARTER : '0) : z_q;
	assign diff = 23'(angle) - 23'(pc2rs_pkg::WIN_LO_FX);
	assign prod2 = 27'(prod_s1[28:18]) * 27'(pc2rs_pkg::RECIP3);
	assign sel_ok = ({22'd0, sel_q} < NUM_BINS);

	always_ff @(posedge clk) begin
		if (cmd.scale) begin
			prod_s1 <= 29'(diff[21:0]) * 29'(pc2rs_pkg::BIN_NUM);
			win_s1 <= (angle >= pc2rs_pkg::WIN_LO_FX) && (angle <= pc2rs_pkg::WIN_HI_FX);
		end
		if (cmd.divide) begin
			bin_s2 <= prod2[26:17];
			ok_s2 <= win_s1 && ({22'd0, prod2[26:17]} < NUM_BINS);
		end
		if (cmd.lookup) begin
			ok_s3 <= ok_s2;
		end
	end

	always_comb begin
		we = 1'b0;
		wa = clr_addr;
		wd = pc2rs_pkg::EMPTY_RANGE;
		if (cmd.clear_wr) begin
			we = 1'b1;
		end else if (cmd.update) begin
			we = ok_s3 && (root_q < {19'd0, rdata_q});
			wa = AW'(bin_s2);
			wd = root_q[12:0];
		end else if (cmd.reply) begin
			we = sel_ok;
			wa = AW'(sel_q);
		end
		re = cmd.lookup || cmd.rd_read;
		ra = cmd.lookup ? AW'(bin_s2) : AW'(sel_q);
	end

	always_ff @(posedge clk) begin
		if (we) begin
			bin_mem_q[wa] <= wd;
		end
		if (re) begin
			rdata_q <= bin_mem_q[ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.reply) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.reply) begin
			range_q <= sel_ok ? rdata_q : pc2rs_pkg::EMPTY_RANGE;
			echo_q <= sel_q;
		end
	end

	assign out_valid = out_valid_q;
	assign range_mm = range_q;
	assign bin_echo = echo_q;

endmodule

[rtl/core/point_cloud_to_range_scan.sv]
// Accumulate request: from acceptance back to ready it runs 20 CORDIC steps in one
// shared shift-add unit, then scale, divide-by-three, bin read and bin write.
// Read request: the bin is read, then the result is registered once the output is not stalled.
// The block takes no new request until the one in hand is done.
// Reset (arst_n, asynchronous) clears control and then sweeps the bin memory to empty,
// one bin per cycle; no request is accepted until every bin is cleared.
module point_cloud_to_range_scan #(
	parameter int NUM_BINS = pc2rs_pkg::NUM_BINS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               operation,
	input  logic signed [15:0] fwd_mm,
	input  logic signed [15:0] side_mm,
	input  logic signed [15:0] vert_mm,
	input  logic               point_invalid,
	input  logic [9:0]         bin_select,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [12:0]        range_mm,
	output logic [9:0]         bin_echo,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic signed [15:0] cfg_data
);

	// The controller sequences each request; the datapath holds the CORDIC
	// bearing unit, the bit-serial square root, the bin scaler and the bin memory.
	pc2rs_pkg::cmd_t            cmd;
	pc2rs_pkg::status_t         status;
	logic [$clog2(NUM_BINS)-1:0] clr_addr;

	// Height limits are plain registers and can always take a write.
	assign cfg_ready = 1'b1;

	pc2rs_ctrl #(.NUM_BINS(NUM_BINS)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.operation (operation),
		.status    (status),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.clr_addr  (clr_addr)
	);

	pc2rs_dp #(.NUM_BINS(NUM_BINS)) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.clr_addr      (clr_addr),
		.status        (status),
		.fwd_mm        (fwd_mm),
		.side_mm       (side_mm),
		.vert_mm       (vert_mm),
		.point_invalid (point_invalid),
		.bin_select    (bin_select),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.range_mm      (range_mm),
		.bin_echo      (bin_echo)
	);

endmodule

[rtl/core/pc2rs_checker.sv]
`include "point_cloud_to_range_scan_macros.svh"

module pc2rs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        operation,
	input logic        out_valid,
	input logic        out_stall,
	input logic [12:0] range_mm
);

	`PC2RS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(range_mm))
	`PC2RS_ASSERT_NOW(a_range_bound, out_valid, range_mm <= pc2rs_pkg::EMPTY_RANGE)
	`PC2RS_ASSERT_NEXT(a_point_silent, in_valid && !in_stall && (operation == pc2rs_pkg::OP_ACCUM), !$rose(out_valid))

endmodule

bind point_cloud_to_range_scan pc2rs_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.operation (operation),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.range_mm  (range_mm)
);

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;

	// Register indexes that the block does not decode.
	localparam logic [1:0] CFG_SPARE  = 2'd2;
	localparam logic [1:0] CFG_UNUSED = 2'd3;
	localparam int SCAN_BINS = pc2rs_pkg::NUM_BINS_DEF;
	// Long enough for an accepted point to finish, with margin to spare.
	localparam int SETTLE_CYCLES = 40;
	localparam int CYCLE_LIMIT = 600000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic operation;
	logic signed [15:0] fwd_mm;
	logic signed [15:0] side_mm;
	logic signed [15:0] vert_mm;
	logic point_invalid;
	logic [9:0] bin_select;
	logic out_valid;
	logic out_stall;
	logic [12:0] range_mm;
	logic [9:0] bin_echo;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic signed [15:0] cfg_data;

	point_cloud_to_range_scan i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.fwd_mm(fwd_mm),
		.side_mm(side_mm),
		.vert_mm(vert_mm),
		.point_invalid(point_invalid),
		.bin_select(bin_select),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.range_mm(range_mm),
		.bin_echo(bin_echo),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// One expected bin read-out, in the order the reads were accepted.
	typedef struct {
		logic [12:0] range_mm;
		logic [9:0]  bin;
	} scan_reading_t;

	scan_reading_t pending_readings[$];

	// Our own copy of the scan memory and the height window.
	logic [12:0] scan_bins [SCAN_BINS];
	logic signed [15:0] height_lo;
	logic signed [15:0] height_hi;

	int mismatches;
	int cycle_count;
	int send_idle_pct;
	int recv_idle_pct;
	// Toggling this starts a long receiver hold-off whose length is set by hold_len.
	logic hold_trigger;
	logic hold_seen;
	int hold_len;
	int hold_left;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Bearing of (fwd, side) for fwd > 0 in units of 2^-20 rad, twenty vectoring steps.
	function automatic longint bearing_fx(input longint fwd, input longint side);
		longint x, y, z, xs, ys;
		x = fwd;
		y = side;
		z = 0;
		for (int i = 0; i < pc2rs_pkg::CORDIC_STEPS; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + atan_ref(i);
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - atan_ref(i);
			end
		end
		return z;
	endfunction

	function automatic longint atan_ref(input int i);
		longint tab [20] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383, 8192,
			4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2};
		return tab[i];
	endfunction

	function automatic longint floor_sqrt(input longint n);
		longint root, bit_v;
		root = 0;
		bit_v = longint'(1) << 40;
		while (bit_v > n)
			bit_v = bit_v >> 2;
		while (bit_v != 0) begin
			if (n >= root + bit_v) begin
				n = n - (root + bit_v);
				root = (root >> 1) + bit_v;
			end else begin
				root = root >> 1;
			end
			bit_v = bit_v >> 2;
		end
		return root;
	endfunction

	// Applies one accepted request to the scan copy and queues any read-out.
	task automatic predict_scan(input logic op, input logic signed [15:0] f,
		input logic signed [15:0] s, input logic signed [15:0] v, input logic inv,
		input logic [9:0] sel);
		scan_reading_t rd;
		longint angle, bin, rng;
		if (op == pc2rs_pkg::OP_READ) begin
			rd.bin = sel;
			rd.range_mm = pc2rs_pkg::EMPTY_RANGE;
			if (sel < SCAN_BINS) begin
				rd.range_mm = scan_bins[sel];
				scan_bins[sel] = pc2rs_pkg::EMPTY_RANGE;
			end
			pending_readings.push_back(rd);
			return;
		end
		if (inv || v > height_hi || v < height_lo || f < 0)
			return;
		if (f == 0) begin
			if (s > 0)
				return;
			angle = (s < 0) ? longint'(pc2rs_pkg::NEG_QUARTER) : 0;
		end else begin
			angle = bearing_fx(f, s);
		end
		if (angle < longint'(pc2rs_pkg::WIN_LO_FX) || angle > longint'(pc2rs_pkg::WIN_HI_FX))
			return;
		bin = ((angle - longint'(pc2rs_pkg::WIN_LO_FX)) * 125) / 786432;
		if (bin >= SCAN_BINS)
			return;
		rng = floor_sqrt(longint'(f) * f + longint'(s) * s);
		if (rng < scan_bins[bin])
			scan_bins[bin] = rng[12:0];
	endtask

	// Offers one request and returns at the edge where it is taken. Valid stays high
	// afterwards so back-to-back requests can follow without a gap; end_stream lowers it.
	task automatic send_request(input logic op, input logic signed [15:0] f,
		input logic signed [15:0] s, input logic signed [15:0] v, input logic inv,
		input logic [9:0] sel);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		operation <= op;
		fwd_mm <= f;
		side_mm <= s;
		vert_mm <= v;
		point_invalid <= inv;
		bin_select <= sel;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_scan(op, f, s, v, inv, sel);
	endtask

	task automatic end_stream();
		in_valid <= 1'b0;
	endtask

	// Waits until every read-out has come and the point pipeline has emptied.
	task automatic drain();
		end_stream();
		wait (pending_readings.size() == 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [1:0] idx, input logic signed [15:0] val);
		drain();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		if (idx == pc2rs_pkg::CFG_MIN_HEIGHT)
			height_lo = val;
		else if (idx == pc2rs_pkg::CFG_MAX_HEIGHT)
			height_hi = val;
		cfg_valid <= 1'b0;
	endtask

	task automatic set_heights(input logic signed [15:0] lo, input logic signed [15:0] hi);
		write_register(pc2rs_pkg::CFG_MIN_HEIGHT, lo);
		write_register(pc2rs_pkg::CFG_MAX_HEIGHT, hi);
	endtask

	// A point that mostly lands inside the window and the height band, so bins fill up.
	task automatic send_random_point();
		logic signed [15:0] f, s, v;
		int span;
		span = ($urandom_range(9) == 0) ? 32767 : 7000;
		f = 16'($urandom_range(span));
		s = 16'($signed($urandom_range(2 * span)) - span);
		v = 16'(int'($urandom_range(int'(height_hi) - int'(height_lo))) + int'(height_lo));
		if ($urandom_range(19) == 0)
			f = 16'($urandom);
		if ($urandom_range(19) == 0)
			v = 16'($urandom);
		if ($urandom_range(29) == 0)
			f = 0;
		send_request(pc2rs_pkg::OP_ACCUM, f, s, v, $urandom_range(15) == 0, 10'($urandom));
	endtask

	task automatic send_random_read();
		logic [9:0] sel;
		sel = ($urandom_range(15) == 0) ? 10'($urandom) : 10'($urandom_range(SCAN_BINS - 1));
		send_request(pc2rs_pkg::OP_READ, 16'($urandom), 16'($urandom), 16'($urandom),
			1'($urandom), sel);
	endtask

	task automatic send_random_mix(input int count);
		repeat (count) begin
			if ($urandom_range(99) < 55)
				send_random_point();
			else
				send_random_read();
		end
	endtask

	// Extremes of the fields and each corner the bearing and range logic has.
	task automatic test_directed();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_heights(-16'sd32768, 16'sd32767);
		send_request(pc2rs_pkg::OP_ACCUM, 16'sd1000, 16'sd0, -16'sd32768, 1'b0, 10'd0);
		send_request(pc2rs_pkg::OP_ACCUM, 16'sd32767, 16'sd32767, 16'sd32767, 1'b0, 10'd0);
		send_request(pc2rs_pkg::OP_ACCUM, 16'sd300, -16'sd32768, 16'sd0, 1'b0, 10'd0);
		send_request(pc2rs_pkg::OP_ACCUM, 16'sd1, 16'sd32767, 16'sd0, 1'b0, 10'd0);
		// A point behind the sensor is outside the window.
		send_request(pc2rs_pkg::OP_ACCUM, -16'sd32768, 16'sd5, 16'sd0, 1'b0, 10'd0);
		// On the side axis: the positive side is dropped, the negative side lands in bin 0.
		send_request(pc2rs_pkg::OP_ACCUM, 16'sd0, 16'sd200, 16'sd0, 1'b0, 10'd0);
		send_request(pc2rs_pkg::OP_ACCUM, 16'sd0, -16'sd1500, 16'sd0, 1'b0, 10'd0);
		// The origin has bearing zero and range zero.
		send_request(pc2rs_pkg::OP_ACCUM, 16'sd0, 16'sd0, 16'sd0, 1'b0, 10'd0);
		// An invalid point with otherwise good coordinates changes nothing.
		send_request(pc2rs_pkg::OP_ACCUM, 16'sd50, 16'sd0, 16'sd0, 1'b1, 10'd1023);
		send_request(pc2rs_pkg::OP_READ, 16'sd0, 16'sd0, 16'sd0, 1'b0, 10'd0);
		send_request(pc2rs_pkg::OP_READ, 16'sd0, 16'sd0, 16'sd0, 1'b0, 10'd261);
		send_request(pc2rs_pkg::OP_READ, 16'sd0, 16'sd0, 16'sd0, 1'b0, 10'd261);
		send_request(pc2rs_pkg::OP_READ, -16'sd1, -16'sd1, -16'sd1, 1'b1, 10'd522);
		// Reads beyond the table answer empty and leave the memory alone.
		send_request(pc2rs_pkg::OP_READ, 16'sd0, 16'sd0, 16'sd0, 1'b0, 10'd523);
		send_request(pc2rs_pkg::OP_READ, 16'sd0, 16'sd0, 16'sd0, 1'b0, 10'd1023);
		// Crossed heights drop every point.
		set_heights(16'sd10, -16'sd10);
		send_request(pc2rs_pkg::OP_ACCUM, 16'sd400, 16'sd10, 16'sd0, 1'b0, 10'd0);
		send_request(pc2rs_pkg::OP_READ, 16'sd0, 16'sd0, 16'sd0, 1'b0, 10'd262);
		// Unknown register indexes are ignored.
		write_register(CFG_UNUSED, -16'sd32768);
		write_register(CFG_SPARE, 16'sd32767);
		set_heights(16'sd0, 16'sd0);
		send_request(pc2rs_pkg::OP_ACCUM, 16'sd400, 16'sd10, 16'sd0, 1'b0, 10'd0);
		send_request(pc2rs_pkg::OP_ACCUM, 16'sd400, 16'sd10, 16'sd1, 1'b0, 10'd0);
		send_request(pc2rs_pkg::OP_READ, 16'sd0, 16'sd0, 16'sd0, 1'b0, 10'd262);
		drain();
	endtask

	task automatic test_random_phase(input int count, input int s_pct, input int r_pct,
		input logic signed [15:0] lo, input logic signed [15:0] hi);
		set_heights(lo, hi);
		send_idle_pct = s_pct;
		recv_idle_pct = r_pct;
		send_random_mix(count);
		drain();
	endtask

	// The receiver holds off for a long stretch while reads keep coming, so the block
	// backs up; afterwards the sender pauses until everything is back.
	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		hold_len = 600;
		hold_trigger <= ~hold_trigger;
		repeat (20)
			send_random_read();
		send_random_mix(20);
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = pc2rs_pkg::OP_ACCUM;
		fwd_mm = '0;
		side_mm = '0;
		vert_mm = '0;
		point_invalid = 1'b0;
		bin_select = '0;
		cfg_valid = 1'b0;
		cfg_index = pc2rs_pkg::CFG_MIN_HEIGHT;
		cfg_data = '0;
		hold_trigger = 1'b0;
		hold_len = 0;
		mismatches = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		height_lo = 16'sd100;
		height_hi = 16'sd150;
		for (int i = 0; i < SCAN_BINS; i++)
			scan_bins[i] = pc2rs_pkg::EMPTY_RANGE;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_random_phase(220, 11, 83, 16'sd100, 16'sd150);
		test_random_phase(220, 83, 11, -16'sd32768, 16'sd32767);
		test_random_phase(150, 0, 0, -16'sd500, 16'sd2000);
		test_backpressure();

		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Receiver side: random stall, overridden by a counted hold-off when one is asked for.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left <= 0;
			hold_seen <= 1'b0;
		end else begin
			hold_seen <= hold_trigger;
			if (hold_seen != hold_trigger) begin
				hold_left <= hold_len;
				out_stall <= 1'b1;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// Every read-out taken is compared with the oldest one predicted.
	always @(posedge clk) begin
		scan_reading_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_readings.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("Unexpected read-out: range %0d bin %0d", range_mm, bin_echo);
			end else begin
				want = pending_readings.pop_front();
				if (range_mm !== want.range_mm || bin_echo !== want.bin) begin
					mismatches++;
					if (mismatches <= 10)
						$display("Read-out mismatch: expected range %0d bin %0d, got %0d bin %0d",
							want.range_mm, want.bin, range_mm, bin_echo);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

endmodule

[files.f]
+incdir+rtl/core
rtl/core/pc2rs_pkg.sv
rtl/core/pc2rs_ctrl.sv
rtl/core/pc2rs_dp.sv
rtl/core/point_cloud_to_range_scan.sv
rtl/core/pc2rs_checker.sv
verif/testbench.sv
